// File: rtl/core/lru_pr_pkg.sv
`timescale 1ns / 1ps

package lru_pr_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 16;
  localparam int unsigned DEF_PAGE_BITS   = 16;
  localparam int unsigned DEF_AGE_BITS    = 16;

  localparam int unsigned PAGE_PORT_W = 16;
  localparam int unsigned SLOT_PORT_W = 4;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CFG_W       = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // flags riding with the probe down the chain
  typedef struct packed {
    logic tok;
    logic found;
    logic best_valid;
  } probe_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } scan_state_t;

endpackage

// File: rtl/core/lru_pr_cell.sv
`timescale 1ns / 1ps

module lru_pr_cell
  import lru_pr_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned SLOT_W    = 4,
  parameter int unsigned PAGE_BITS = DEF_PAGE_BITS,
  parameter int unsigned AGE_BITS  = DEF_AGE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 active,
  // probe from the left neighbor
  input  probe_flags_t         flags_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [AGE_BITS-1:0]  bage_i,
  input  logic [SLOT_W-1:0]    bslot_i,
  input  logic [PAGE_BITS-1:0] bpage_i,
  // probe to the right neighbor
  output probe_flags_t         flags_o,
  output logic [PAGE_BITS-1:0] page_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [AGE_BITS-1:0]  bage_o,
  output logic [SLOT_W-1:0]    bslot_o,
  output logic [PAGE_BITS-1:0] bpage_o,
  // broadcast update at the end of the scan
  input  logic                 commit_en,
  input  logic [SLOT_W-1:0]    commit_slot,
  input  logic [PAGE_BITS-1:0] commit_page
);

  localparam logic [SLOT_W-1:0]   MY_SLOT = SLOT_W'(IDX);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam bit                  FIRST   = (IDX == 0);

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic [AGE_BITS-1:0]  age_r;
  logic [AGE_BITS-1:0]  age_inc;

  probe_flags_t         flags_r,  flags_nxt;
  logic [PAGE_BITS-1:0] ppage_r;
  logic [SLOT_W-1:0]    slot_r,   slot_nxt;
  logic [AGE_BITS-1:0]  bage_r,   bage_nxt;
  logic [SLOT_W-1:0]    bslot_r,  bslot_nxt;
  logic [PAGE_BITS-1:0] bpage_r,  bpage_nxt;

  logic match, take_over;

  assign age_inc   = (age_r == AGE_MAX) ? age_r : age_r + AGE_BITS'(1);
  assign match     = active && !flags_i.found && valid_r && (page_r == page_i);
  // strict compare keeps the lower index on a tie
  assign take_over = active && (FIRST || (age_inc > bage_i));

  always_comb begin
    flags_nxt  = flags_i;
    slot_nxt   = slot_i;
    bage_nxt   = bage_i;
    bslot_nxt  = bslot_i;
    bpage_nxt  = bpage_i;
    if (match) begin
      flags_nxt.found = 1'b1;
      slot_nxt        = MY_SLOT;
    end
    if (take_over) begin
      bage_nxt             = age_inc;
      bslot_nxt            = MY_SLOT;
      bpage_nxt            = page_r;
      flags_nxt.best_valid = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
    ppage_r <= page_i;
    slot_r  <= slot_nxt;
    bage_r  <= bage_nxt;
    bslot_r <= bslot_nxt;
    bpage_r <= bpage_nxt;
  end

  // entry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
    end else if (commit_en && active) begin
      if (commit_slot == MY_SLOT) begin
        valid_r <= 1'b1;
        age_r   <= '0;
      end else begin
        age_r <= age_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_en && active && (commit_slot == MY_SLOT)) begin
      page_r <= commit_page;
    end
  end

  assign flags_o = flags_r;
  assign page_o  = ppage_r;
  assign slot_o  = slot_r;
  assign bage_o  = bage_r;
  assign bslot_o = bslot_r;
  assign bpage_o = bpage_r;

endmodule

// File: rtl/core/lru_page_replacement_unit.sv
`timescale 1ns / 1ps

// channel  | ports                                   | direction | beat
// ---------+-----------------------------------------+-----------+----------------------------
// in       | in_valid/in_ready, in_page_number       | sink      | one page reference
// out      | out_valid/out_ready, out_hit, out_slot, | source    | one result per reference
//          | out_evicted_valid/page, out_*_count     |           |
// cfg      | cfg_wr_en, cfg_wr_data                  | sink      | entries in use, no wait
//
// in a beat the probe walks one cell per cycle down the chain, the cells are
// updated as it leaves the last cell, then the result parks in a pending
// register before the output register.
// one reference is in the chain at a time; the next is taken once the pending
// register has drained into the output register.
// out_ready low stalls only the output register; a scan already running finishes.
// rst_n is synchronous: entries empty, ages zero, counters zero, entries in use 16.

module lru_page_replacement_unit
  import lru_pr_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int unsigned PAGE_BITS   = DEF_PAGE_BITS,
  parameter int unsigned AGE_BITS    = DEF_AGE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PAGE_PORT_W-1:0] in_page_number,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_hit,
  output logic [SLOT_PORT_W-1:0] out_slot,
  output logic                   out_evicted_valid,
  output logic [PAGE_PORT_W-1:0] out_evicted_page,
  output logic [CNT_W-1:0]       out_fault_count,
  output logic [CNT_W-1:0]       out_request_count,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data
);

  localparam int unsigned SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // configuration
  logic [CFG_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // cell i takes part when i < max(1, count); cells past the top don't exist
  logic [MAX_ENTRIES-1:0] active;

  // probe chain, position 0 is the launch point
  probe_flags_t         ch_flags [0:MAX_ENTRIES];
  logic [PAGE_BITS-1:0] ch_page  [0:MAX_ENTRIES];
  logic [SLOT_W-1:0]    ch_slot  [0:MAX_ENTRIES];
  logic [AGE_BITS-1:0]  ch_bage  [0:MAX_ENTRIES];
  logic [SLOT_W-1:0]    ch_bslot [0:MAX_ENTRIES];
  logic [PAGE_BITS-1:0] ch_bpage [0:MAX_ENTRIES];
  logic [MAX_ENTRIES:0] tok_vec;

  logic                 commit_en;
  logic [SLOT_W-1:0]    commit_slot;
  logic [PAGE_BITS-1:0] commit_page;

  logic        in_acc;
  logic        pend_vld_r;
  scan_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE) && !pend_vld_r;
  assign in_acc   = in_valid && in_ready;

  // launch: empty probe carrying the masked page
  always_comb begin
    ch_flags[0]     = '0;
    ch_flags[0].tok = in_acc;
    ch_page[0]      = PAGE_BITS'(in_page_number);
    ch_slot[0]      = '0;
    ch_bage[0]      = '0;
    ch_bslot[0]     = '0;
    ch_bpage[0]     = '0;
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign active[gi] = 1'b1;
      end else begin : g_rest
        assign active[gi] = ({1'b0, cfg_r} > (CFG_W+1)'(gi));
      end

      lru_pr_cell #(
        .IDX       (gi),
        .SLOT_W    (SLOT_W),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .active      (active[gi]),
        .flags_i     (ch_flags[gi]),
        .page_i      (ch_page[gi]),
        .slot_i      (ch_slot[gi]),
        .bage_i      (ch_bage[gi]),
        .bslot_i     (ch_bslot[gi]),
        .bpage_i     (ch_bpage[gi]),
        .flags_o     (ch_flags[gi+1]),
        .page_o      (ch_page[gi+1]),
        .slot_o      (ch_slot[gi+1]),
        .bage_o      (ch_bage[gi+1]),
        .bslot_o     (ch_bslot[gi+1]),
        .bpage_o     (ch_bpage[gi+1]),
        .commit_en   (commit_en),
        .commit_slot (commit_slot),
        .commit_page (commit_page)
      );
    end

    for (gi = 0; gi <= MAX_ENTRIES; gi++) begin : g_tok
      assign tok_vec[gi] = ch_flags[gi].tok;
    end
  endgenerate

  // probe leaving the last cell decides the update
  assign commit_en   = ch_flags[MAX_ENTRIES].tok;
  assign commit_slot = ch_flags[MAX_ENTRIES].found ? ch_slot[MAX_ENTRIES]
                                                   : ch_bslot[MAX_ENTRIES];
  assign commit_page = ch_page[MAX_ENTRIES];

  logic evict;
  assign evict = !ch_flags[MAX_ENTRIES].found && ch_flags[MAX_ENTRIES].best_valid;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (commit_en) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // running counters
  logic [CNT_W-1:0] fault_cnt_r, fault_cnt_nxt;
  logic [CNT_W-1:0] req_cnt_r,   req_cnt_nxt;

  assign fault_cnt_nxt = ch_flags[MAX_ENTRIES].found ? fault_cnt_r
                                                     : fault_cnt_r + CNT_W'(1);
  assign req_cnt_nxt   = req_cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_cnt_r <= '0;
      req_cnt_r   <= '0;
    end else if (commit_en) begin
      fault_cnt_r <= fault_cnt_nxt;
      req_cnt_r   <= req_cnt_nxt;
    end
  end

  // pending result, then output register
  logic                   pend_hit_r;
  logic [SLOT_PORT_W-1:0] pend_slot_r;
  logic                   pend_ev_vld_r;
  logic [PAGE_PORT_W-1:0] pend_ev_page_r;
  logic [CNT_W-1:0]       pend_fault_r;
  logic [CNT_W-1:0]       pend_req_r;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [SLOT_PORT_W-1:0] out_slot_r;
  logic                   out_ev_vld_r;
  logic [PAGE_PORT_W-1:0] out_ev_page_r;
  logic [CNT_W-1:0]       out_fault_r;
  logic [CNT_W-1:0]       out_req_r;

  logic out_load;
  assign out_load = pend_vld_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (commit_en) begin
      pend_vld_r <= 1'b1;
    end else if (out_load) begin
      pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_en) begin
      pend_hit_r     <= ch_flags[MAX_ENTRIES].found;
      pend_slot_r    <= SLOT_PORT_W'(commit_slot);
      pend_ev_vld_r  <= evict;
      pend_ev_page_r <= evict ? PAGE_PORT_W'(ch_bpage[MAX_ENTRIES]) : '0;
      pend_fault_r   <= fault_cnt_nxt;
      pend_req_r     <= req_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r     <= pend_hit_r;
      out_slot_r    <= pend_slot_r;
      out_ev_vld_r  <= pend_ev_vld_r;
      out_ev_page_r <= pend_ev_page_r;
      out_fault_r   <= pend_fault_r;
      out_req_r     <= pend_req_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_fault_r;
  assign out_request_count = out_req_r;

`ifndef SYNTHESIS
  // only one probe in flight along the chain
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one probe in the cell chain");

  // a launched probe reaches the end of the chain after passing the register in each cell
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(MAX_ENTRIES) commit_en)
    else $error("probe did not leave the chain on time");

  // no launch while a probe is still walking
  a_no_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_vec[MAX_ENTRIES:1]) |-> !in_ready)
    else $error("input taken during a scan");

  // a finished scan always lands in the pending register
  a_commit_pend: assert property (@(posedge clk) disable iff (!rst_n)
    commit_en |=> pend_vld_r)
    else $error("scan result lost");

  // pending never drained into a full, stalled output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && pend_vld_r) |=> pend_vld_r)
    else $error("pending result dropped while output stalled");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lru_pr_pkg::*;

  // predictor sizes follow the block's default parameters
  localparam int unsigned SLOTS         = DEF_MAX_ENTRIES;
  localparam int unsigned AGE_CEIL      = (1 << DEF_AGE_BITS) - 1;
  localparam int unsigned HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int unsigned HOLD_AT_BEAT  = 30;     // result beat that starts it
  localparam int unsigned WATCHDOG_MAX  = 4000;   // cycles with no beat on either side
  localparam int unsigned PHASE_ITEMS   = 48;
  localparam int unsigned TAIL_CYCLES   = 40;

  // one expected result beat
  typedef struct packed {
    logic                   hit;
    logic [SLOT_PORT_W-1:0] slot;
    logic                   evicted_valid;
    logic [PAGE_PORT_W-1:0] evicted_page;
    logic [CNT_W-1:0]       fault_count;
    logic [CNT_W-1:0]       request_count;
  } lookup_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PAGE_PORT_W-1:0] in_page_number = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_hit;
  logic [SLOT_PORT_W-1:0] out_slot;
  logic                   out_evicted_valid;
  logic [PAGE_PORT_W-1:0] out_evicted_page;
  logic [CNT_W-1:0]       out_fault_count;
  logic [CNT_W-1:0]       out_request_count;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  // mirror of the page store
  logic [PAGE_PORT_W-1:0] store_page [SLOTS];
  logic                   store_full [SLOTS];
  int unsigned            store_age  [SLOTS];
  logic [CFG_W-1:0]       span_reg;
  logic [CNT_W-1:0]       faults_so_far;
  logic [CNT_W-1:0]       refs_so_far;

  logic [PAGE_PORT_W-1:0] page_stream [$];     // references waiting for the driver
  lookup_result_t         pending_lookups [$]; // results owed by the block
  logic [PAGE_PORT_W-1:0] hot_pages [$];       // working set of the current phase
  lookup_result_t         got_want;

  int unsigned failures = 0;
  int unsigned beats_received = 0;
  int unsigned hits_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned settings_used = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned pick_tx;
  int unsigned pick_rx;
  bit          drv_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_done = 1'b0;

  lru_page_replacement_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_count  (out_fault_count),
    .out_request_count(out_request_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // zero counts as one entry, anything past the store size saturates
  function automatic int unsigned live_entries(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > SLOTS) return SLOTS;
    return v;
  endfunction

  // one page reference against the mirrored store
  function automatic lookup_result_t lru_access(logic [PAGE_PORT_W-1:0] page);
    lookup_result_t r;
    int unsigned n;
    int found_at;
    int unsigned victim;
    r = '0;
    n = live_entries(span_reg);
    found_at = -1;
    for (int i = 0; i < n; i++) begin
      if (found_at < 0 && store_full[i] && store_page[i] == page) found_at = i;
    end
    // every live entry ages, empty ones too, pinned at the ceiling
    for (int i = 0; i < n; i++) begin
      if (store_age[i] < AGE_CEIL) store_age[i]++;
    end
    if (found_at >= 0) begin
      r.hit = 1'b1;
      victim = found_at;
    end else begin
      // oldest live entry, first index wins a tie
      victim = 0;
      for (int i = 1; i < n; i++) begin
        if (store_age[i] > store_age[victim]) victim = i;
      end
      if (store_full[victim]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = store_page[victim];
      end
      store_page[victim] = page;
      store_full[victim] = 1'b1;
      faults_so_far++;
    end
    store_age[victim] = 0;
    refs_so_far++;
    r.slot          = SLOT_PORT_W'(victim);
    r.fault_count   = faults_so_far;
    r.request_count = refs_so_far;
    return r;
  endfunction

  // mostly the phase's working set so hits and evictions both happen
  function automatic logic [PAGE_PORT_W-1:0] draw_page();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return hot_pages[$urandom_range(0, hot_pages.size() - 1)];
    if (p < 90) return PAGE_PORT_W'($urandom);
    return p[0] ? '1 : '0;
  endfunction

  // driver: presents queued references, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_lookups.push_back(lru_access(in_page_number));
        if ($urandom_range(0, 39) == 0) drv_calm = ~drv_calm;
        if (drv_calm) begin
          gap_left = 0;
        end else begin
          pick_tx = $urandom_range(0, 99);
          if (pick_tx < 55) gap_left = 0;
          else if (pick_tx < 90) gap_left = $urandom_range(1, 4);
          else gap_left = $urandom_range(10, 40);
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && page_stream.size() > 0) begin
          in_valid       <= 1'b1;
          in_page_number <= page_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // monitor: checks each result beat and drives out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_received++;
        if (pending_lookups.size() == 0) begin
          $error("result beat with no reference outstanding");
          failures++;
        end else begin
          got_want = pending_lookups.pop_front();
          if (out_hit !== got_want.hit) begin
            $error("hit: expected %0d, got %0d", got_want.hit, out_hit);
            failures++;
          end
          if (out_slot !== got_want.slot) begin
            $error("slot: expected %0d, got %0d", got_want.slot, out_slot);
            failures++;
          end
          if (out_evicted_valid !== got_want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d",
                   got_want.evicted_valid, out_evicted_valid);
            failures++;
          end
          if (out_evicted_page !== got_want.evicted_page) begin
            $error("evicted_page: expected %h, got %h",
                   got_want.evicted_page, out_evicted_page);
            failures++;
          end
          if (out_fault_count !== got_want.fault_count) begin
            $error("fault_count: expected %0d, got %0d",
                   got_want.fault_count, out_fault_count);
            failures++;
          end
          if (out_request_count !== got_want.request_count) begin
            $error("request_count: expected %0d, got %0d",
                   got_want.request_count, out_request_count);
            failures++;
          end
          if (got_want.hit) hits_seen++;
          else faults_seen++;
        end
        if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
      end
      if (!rx_calm && hold_left == 0) begin
        pick_rx = $urandom_range(0, 99);
        if (pick_rx < 15) hold_left = $urandom_range(1, 3);
        else if (pick_rx < 18) hold_left = $urandom_range(8, 40);
      end
      // one long hold so the block backs up and stalls its input
      if (beats_received == HOLD_AT_BEAT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_MAX) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_MAX);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (page_stream.size() != 0 || in_valid || pending_lookups.size() != 0);
  endtask

  // register write, only while nothing is in flight
  task automatic write_entries(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    span_reg = v;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    logic [PAGE_PORT_W-1:0] dup_page;
    logic [CFG_W-1:0]       span;
    int unsigned            live;

    for (int i = 0; i < SLOTS; i++) begin
      store_page[i] = '0;
      store_full[i] = 1'b0;
      store_age[i]  = 0;
    end
    span_reg      = CFG_RESET;
    faults_so_far = '0;
    refs_so_far   = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: fill four entries, hit, evict the least recent
    write_entries(5'd4);
    page_stream = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA,
                    16'h1234, 16'hFFFF, 16'h5555};
    wait_drained();

    // zero entries acts as one; the page in entry 3 is parked out of reach
    dup_page = store_page[3];
    write_entries(5'd0);
    page_stream = '{dup_page, 16'h0F0F, dup_page, dup_page};
    wait_drained();

    // count above the store saturates; the page now sits twice, lowest index hits
    write_entries(5'd31);
    page_stream = '{dup_page, 16'h00FF, 16'hFF00, 16'h8001};
    wait_drained();

    write_entries(5'd1);
    page_stream = '{16'h7FFE, 16'h7FFE};
    wait_drained();

    // random phases at several entry counts
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: span = 5'd16;
        1: span = 5'd2;
        2: span = 5'd9;
        3: span = CFG_W'($urandom_range(0, 31));
        4: span = 5'd5;
        5: span = 5'd12;
        6: span = CFG_W'($urandom_range(17, 31));
        default: span = 5'd3;
      endcase
      wait_drained();
      write_entries(span);
      live = live_entries(span);
      hot_pages.delete();
      repeat (live + $urandom_range(1, live + 1)) hot_pages.push_back(PAGE_PORT_W'($urandom));
      repeat (PHASE_ITEMS) page_stream.push_back(draw_page());
    end
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d references checked over %0d entry-count settings: %0d hits, %0d faults",
             beats_received, settings_used, hits_seen, faults_seen);
    $display("included a %0d-cycle output hold with the input backed up",
             HOLD_CYCLES);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
